>>> design/utf8d_pkg.sv
package utf8d_pkg;

  localparam int unsigned CuWidth       = 21;
  localparam int unsigned DefFifoDepth  = 4;

  localparam logic [CuWidth-1:0] BmpMax      = 21'h00FFFF;
  localparam logic [CuWidth-1:0] UnicodeMax  = 21'h10FFFF;
  localparam logic [CuWidth-1:0] SuppBase    = 21'h010000;
  localparam logic [15:0]        HiSurrBase  = 16'hD800;
  localparam logic [15:0]        LoSurrBase  = 16'hDC00;

  // One decoded point handed from the front end to the back end.
  typedef struct packed {
    logic [CuWidth-1:0] cp;
    logic               err;
  } cmd_t;

endpackage

>>> design/utf8d_front.sv
module utf8d_front import utf8d_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       buffer_end,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic [1:0]         pending;
  logic [CuWidth-1:0] acc;
  logic [1:0]         pending_next;
  logic [CuWidth-1:0] acc_next;
  logic [CuWidth-1:0] acc_shift;
  logic [1:0]         pending_dec;

  assign acc_shift   = {acc[CuWidth-7:0], byte_in[5:0]};
  assign pending_dec = pending - 2'd1;

  always_comb begin
    pending_next = pending;
    acc_next     = acc;
    cmd_push     = 1'b0;
    cmd.cp       = '0;
    cmd.err      = 1'b0;
    if (pending == 2'd0) begin
      priority if (!byte_in[7]) begin
        cmd_push = 1'b1;
        cmd.cp   = {{(CuWidth-8){1'b0}}, byte_in};
      end else if (byte_in[7:6] == 2'b10 || byte_in[7:3] == 5'b11111) begin
        cmd_push = 1'b1;
        cmd.err  = 1'b1;
      end else begin
        priority if (byte_in[7:5] == 3'b110) begin
          acc_next     = {{(CuWidth-5){1'b0}}, byte_in[4:0]};
          pending_next = 2'd1;
        end else if (byte_in[7:4] == 4'b1110) begin
          acc_next     = {{(CuWidth-4){1'b0}}, byte_in[3:0]};
          pending_next = 2'd2;
        end else begin
          acc_next     = {{(CuWidth-3){1'b0}}, byte_in[2:0]};
          pending_next = 2'd3;
        end
        if (buffer_end) begin
          // Truncated at buffer end: drop the partial sequence
          cmd_push     = 1'b1;
          cmd.err      = 1'b1;
          acc_next     = '0;
          pending_next = 2'd0;
        end
      end
    end else begin
      if (byte_in[7:6] != 2'b10) begin
        cmd_push     = 1'b1;
        cmd.err      = 1'b1;
        acc_next     = '0;
        pending_next = 2'd0;
      end else if (pending_dec == 2'd0) begin
        cmd_push     = 1'b1;
        cmd.cp       = acc_shift;
        acc_next     = '0;
        pending_next = 2'd0;
      end else if (buffer_end) begin
        cmd_push     = 1'b1;
        cmd.err      = 1'b1;
        acc_next     = '0;
        pending_next = 2'd0;
      end else begin
        acc_next     = acc_shift;
        pending_next = pending_dec;
      end
    end
    if (!accept) begin
      cmd_push     = 1'b0;
      pending_next = pending;
      acc_next     = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      acc     <= '0;
    end else begin
      pending <= pending_next;
      acc     <= acc_next;
    end
  end

endmodule

>>> design/utf8d_fifo.sv
module utf8d_fifo import utf8d_pkg::*; #(
  parameter int unsigned FifoDepth = DefFifoDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic full,
  output logic empty
);

  localparam int unsigned AddrWidth = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntWidth  = $clog2(FifoDepth + 1);
  localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(FifoDepth - 1);

  cmd_t                 mem [FifoDepth];
  logic [AddrWidth-1:0] wr_ptr;
  logic [AddrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0]  count;
  logic                 do_wr;
  logic                 do_rd;

  assign full    = (count == CntWidth'(FifoDepth));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastAddr) ? '0 : wr_ptr + AddrWidth'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastAddr) ? '0 : rd_ptr + AddrWidth'(1);
      end
      priority if (do_wr && !do_rd) begin
        count <= count + CntWidth'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntWidth'(1);
      end else begin
        count <= count;
      end
    end
  end

endmodule

>>> design/utf8d_back.sv
module utf8d_back import utf8d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               utf16_mode,
  input  cmd_t               cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               empty,
  output logic [CuWidth-1:0] code_unit,
  output logic               error_flag,
  output logic               last
);

  logic               out_valid;
  logic               lo_pend;
  logic [15:0]        lo_unit;
  logic               load;
  logic               split;
  logic               above;
  logic [CuWidth-1:0] offs;
  logic [15:0]        hi_calc;
  logic [15:0]        lo_calc;

  assign empty   = !out_valid;
  assign load    = !out_valid || pop;
  assign cmd_pop = load && !lo_pend && !cmd_empty;

  assign above   = utf16_mode && (cmd.cp > UnicodeMax);
  assign split   = utf16_mode && !cmd.err && (cmd.cp > BmpMax) && !above;
  assign offs    = cmd.cp - SuppBase;
  assign hi_calc = HiSurrBase + {6'd0, offs[19:10]};
  assign lo_calc = LoSurrBase + {6'd0, offs[9:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      lo_pend   <= 1'b0;
    end else if (load) begin
      priority if (lo_pend) begin
        out_valid <= 1'b1;
        lo_pend   <= 1'b0;
      end else if (!cmd_empty) begin
        out_valid <= 1'b1;
        lo_pend   <= split;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (lo_pend) begin
        code_unit  <= {{(CuWidth-16){1'b0}}, lo_unit};
        error_flag <= 1'b0;
        last       <= 1'b1;
      end else if (!cmd_empty) begin
        // Hold the low surrogate until the high one is taken
        code_unit  <= split ? {{(CuWidth-16){1'b0}}, hi_calc} : cmd.cp;
        error_flag <= cmd.err || above;
        last       <= !split;
        lo_unit    <= lo_calc;
      end
    end
  end

endmodule

>>> design/utf8_decoder.sv
// Channel   Handshake              Payload
// input     push / full            byte_in[7:0], buffer_end
// result    empty / pop            code_unit[20:0], error_flag, last
// config    cfg_we                 cfg_wdata (utf16_mode)
//
// A byte is taken every cycle that the decode queue has room; its result is
// queued and then loaded into the result register. A surrogate pair holds the
// result register for its high, then its low unit, with the queue held; else
// the queue drains at one result per cycle while pop is held.
// Synchronous reset clears the sequence state, the queue and the mode.
// A stall on pop fills the queue and then raises full.
module utf8_decoder import utf8d_pkg::*; #(
  parameter int unsigned FifoDepth = DefFifoDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         byte_in,
  input  logic               buffer_end,
  output logic               empty,
  input  logic               pop,
  output logic [CuWidth-1:0] code_unit,
  output logic               error_flag,
  output logic               last,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  logic utf16_mode;
  logic accept;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_in;
  cmd_t cmd_out;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      utf16_mode <= 1'b0;
    end else if (cfg_we) begin
      utf16_mode <= cfg_wdata;
    end
  end

  utf8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_in    (byte_in),
    .buffer_end (buffer_end),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  utf8d_fifo #(
    .FifoDepth (FifoDepth)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .full    (full),
    .empty   (cmd_empty)
  );

  utf8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .utf16_mode (utf16_mode),
    .cmd        (cmd_out),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .code_unit  (code_unit),
    .error_flag (error_flag),
    .last       (last)
  );

endmodule

>>> sim/testbench.sv
module testbench;
  import utf8d_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdlePad    = 10;

  typedef struct packed {
    logic [CuWidth-1:0] unit;
    logic               err;
    logic               fin;
  } unit_rec_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         byte_in = 8'h00;
  logic               buffer_end = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [CuWidth-1:0] code_unit;
  logic               error_flag;
  logic               last;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;

  // decoder state as predicted from the accepted bytes
  logic               split_mode = 1'b0;
  logic [1:0]         seq_pending = '0;
  logic [CuWidth-1:0] seq_acc = '0;
  logic [2:0]         seq_len = '0;

  unit_rec_t          expected_units[$];
  int unsigned        error_count = 0;
  int unsigned        bytes_sent = 0;
  int unsigned        cycle_count = 0;
  logic               send_eager = 1'b0;
  logic               sink_eager = 1'b0;
  logic               hold_req = 1'b0;
  int unsigned        hold_left = 0;
  int unsigned        pop_idle = 0;
  int unsigned        sink_phase = 0;

  utf8_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .byte_in    (byte_in),
    .buffer_end (buffer_end),
    .empty      (empty),
    .pop        (pop),
    .code_unit  (code_unit),
    .error_flag (error_flag),
    .last       (last),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
  endtask

  function automatic void add_unit(input logic [CuWidth-1:0] unit, input logic err,
                                   input logic fin);
    unit_rec_t rec;
    rec.unit = unit;
    rec.err  = err;
    rec.fin  = fin;
    expected_units = {expected_units, rec};
  endfunction

  function automatic void clear_sequence();
    seq_pending = '0;
    seq_acc     = '0;
    seq_len     = '0;
  endfunction

  function automatic void emit_code_point(input logic [CuWidth-1:0] cp);
    logic [CuWidth-1:0] v;
    if (split_mode && cp > BmpMax) begin
      if (cp > UnicodeMax) begin
        add_unit(cp, 1'b1, 1'b1);
      end else begin
        v = cp - SuppBase;
        add_unit({5'd0, HiSurrBase} + {11'd0, v[19:10]}, 1'b0, 1'b0);
        add_unit({5'd0, LoSurrBase} + {11'd0, v[9:0]}, 1'b0, 1'b1);
      end
    end else begin
      add_unit(cp, 1'b0, 1'b1);
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] c, input logic at_end);
    logic [CuWidth-1:0] cp;
    if (seq_pending == 0) begin
      if (c < 8'h80) begin
        clear_sequence();
        add_unit({13'd0, c}, 1'b0, 1'b1);
      end else if (c < 8'hC0 || c >= 8'hF8) begin
        clear_sequence();
        add_unit('0, 1'b1, 1'b1);
      end else begin
        if (c < 8'hE0) begin
          seq_acc = {16'd0, c[4:0]};
          seq_pending = 2'd1;
          seq_len = 3'd2;
        end else if (c < 8'hF0) begin
          seq_acc = {17'd0, c[3:0]};
          seq_pending = 2'd2;
          seq_len = 3'd3;
        end else begin
          seq_acc = {18'd0, c[2:0]};
          seq_pending = 2'd3;
          seq_len = 3'd4;
        end
        if (at_end) begin
          clear_sequence();
          add_unit('0, 1'b1, 1'b1);
        end
      end
    end else if (c[7:6] != 2'b10) begin
      clear_sequence();
      add_unit('0, 1'b1, 1'b1);
    end else begin
      seq_acc = {seq_acc[14:0], c[5:0]};
      seq_pending = seq_pending - 2'd1;
      if (seq_pending == 0) begin
        cp = seq_acc;
        clear_sequence();
        emit_code_point(cp);
      end else if (at_end) begin
        clear_sequence();
        add_unit('0, 1'b1, 1'b1);
      end
    end
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // byte side: predict on every accepted transaction
  always @(posedge clk) begin
    if (!rst && push && !full) predict_byte(byte_in, buffer_end);
  end

  always @(posedge clk) begin : check_results
    unit_rec_t want;
    if (!rst && pop && !empty) begin
      if (expected_units.size() == 0) begin
        report_mismatch("result with nothing expected", {9'd0, code_unit, error_flag, last},
                        32'd0);
      end else begin
        want = expected_units.pop_front();
        if (code_unit !== want.unit)
          report_mismatch("code_unit", {11'd0, code_unit}, {11'd0, want.unit});
        if (error_flag !== want.err)
          report_mismatch("error_flag", {31'd0, error_flag}, {31'd0, want.err});
        if (last !== want.fin)
          report_mismatch("last", {31'd0, last}, {31'd0, want.fin});
      end
    end
  end

  // result side: random pop gaps, eager stretches, and a long hold on request
  always @(posedge clk) begin
    sink_phase <= sink_phase + 1;
    if (sink_phase % 256 == 0) sink_eager <= ($urandom_range(0, 2) == 0);
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HoldCycles;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else if (pop_idle != 0) begin
      pop_idle <= pop_idle - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      pop_idle <= sink_eager ? 0 : pick_gap();
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic at_end);
    int unsigned gap;
    gap = send_eager ? 0 : pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    byte_in <= b;
    buffer_end <= at_end;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  // hold input until every expected result is back, then let the pipe settle
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (expected_units.size() != 0) @(posedge clk);
    repeat (IdlePad) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    split_mode = mode;
  endtask

  task automatic test_single_bytes_and_errors();
    write_mode(1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b0);   // stray continuation as lead
    send_byte(8'hFF, 1'b1);   // invalid lead
    send_byte(8'hC3, 1'b0);   // bad continuation follows
    send_byte(8'h41, 1'b0);
    send_byte(8'hE2, 1'b1);   // truncated at buffer end
  endtask

  task automatic test_multibyte_points();
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hF7, 1'b0);   // largest four-byte value
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_surrogate_split();
    write_mode(1'b1);
    send_byte(8'hF0, 1'b0);   // supplementary point, pair
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0);   // just above the Unicode range
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF0, 1'b0);   // overlong four-byte form, no split
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_backpressure();
    int unsigned k;
    wait_idle();
    hold_req = 1'b1;
    send_eager = 1'b1;
    for (k = 0; k < 12; k++) begin
      send_byte(8'hF0, 1'b0);
      send_byte(8'h90 | 8'($urandom_range(0, 15)), 1'b0);
      send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
      send_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
    end
    send_eager = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_stream(input int unsigned count, input logic mode);
    int unsigned stop_at, kind, len, k, bad_pos;
    logic [7:0] b;
    write_mode(mode);
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) send_eager = ~send_eager;
      kind = $urandom_range(0, 99);
      if (kind < 88) begin
        len = (kind < 75) ? $urandom_range(1, 4) : $urandom_range(2, 4);
        bad_pos = (kind < 75) ? len : $urandom_range(1, len - 1);
        case (len)
          1: b = 8'($urandom_range(0, 127));
          2: b = 8'hC0 | 8'($urandom_range(0, 31));
          3: b = 8'hE0 | 8'($urandom_range(0, 15));
          default: b = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        send_byte(b, $urandom_range(0, 15) == 0);
        for (k = 1; k < len && k <= bad_pos; k++) begin
          if (k == bad_pos) begin
            b = 8'($urandom);
            if (b[7:6] == 2'b10) b[6] = 1'b1;
          end else begin
            b = 8'h80 | 8'($urandom_range(0, 63));
          end
          send_byte(b, $urandom_range(0, 15) == 0);
        end
      end else begin
        send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
    send_eager = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_bytes_and_errors();
    test_multibyte_points();
    test_surrogate_split();
    test_backpressure();
    test_random_stream(180, 1'b1);
    test_random_stream(180, 1'b0);
    test_random_stream(180, 1'b1);
    wait_idle();
    if (error_count == 0 && expected_units.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
